// ----- hw/rtl/hcrc_pkg.sv -----
`default_nettype none

package hcrc_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int TIMER_WIDTH = 16;
	localparam int OUT_WIDTH   = 16;
	localparam int CFG_WIDTH   = 16;
	localparam int REG_INDEX_WIDTH = 3;

	localparam logic [REG_INDEX_WIDTH-1:0] REG_ROTOR_ORIGIN = 3'd0;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_LEAD_STEPS   = 3'd1;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_REV_LIMIT    = 3'd2;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_LIMIT_ENABLE = 3'd3;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_START_MODE   = 3'd4;

	localparam logic CMD_TICK    = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	localparam logic [1:0] MODE_FULL     = 2'd0;
	localparam logic [1:0] MODE_SPEED    = 2'd1;
	localparam logic [1:0] MODE_POSITION = 2'd2;
	localparam logic [1:0] MODE_UNUSED   = 2'd3;

	localparam logic [2:0] ROTOR_INVALID = 3'd7;
	localparam logic [7:0] DUTY_FULL     = 8'hFF;
	localparam logic [2:0] LEAD_RESET    = 3'b010;

	localparam logic [2:0] ROTOR_DECODE [8] = '{
		3'd7, 3'd5, 3'd3, 3'd4, 3'd1, 3'd0, 3'd2, 3'd7
	};

	localparam logic [5:0] GATE_TABLE [6] = '{
		6'h12, 6'h18, 6'h09, 6'h21, 6'h24, 6'h06
	};

	typedef struct packed {
		logic       cmd;
		logic [2:0] hall;
		logic [7:0] speed_duty;
		logic [7:0] position_duty;
	} hcrc_in_t;

	typedef struct packed {
		logic [2:0]           low_gates;
		logic [2:0]           high_gates;
		logic [7:0]           duty;
		logic [OUT_WIDTH-1:0] rev_count;
		logic [OUT_WIDTH-1:0] rev_period;
		logic [1:0]           mode;
	} hcrc_out_t;

endpackage

`default_nettype wire

// ----- hw/rtl/hcrc_stream_if.sv -----
`default_nettype none

interface hcrc_in_if import hcrc_pkg::*;;
	logic     valid;
	logic     ready;
	hcrc_in_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface hcrc_out_if import hcrc_pkg::*;;
	logic      valid;
	logic      ready;
	hcrc_out_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/hall_commutator_rev_counter.sv -----
// Hall-sensor six-step commutator with revolution counter.
// sensor (sink): one request per tick carrying cmd, the three Hall bits and the
//   speed and position duties; cmd restart clears the counters and loads start_mode.
// result (source): one request per accepted input with the low/high gate pattern,
//   duty, revolution count, period between sensor-one rising edges and mode.
// wr_en / wr_index / wr_data: register writes, to be issued only while the block is idle.
// A request passes the input register, then the state registers once result is free.
// Throughput: one request per clock while result is free; the state update of
//   one tick is a single compare/increment pass from the input register into
//   the state registers, which also form the result register.
// Reset: gates off, duty 255, mode full duty, counters and period zero,
//   registers back to origin 0, lead +2, limit 0, handover off, start mode 0.
// Stall: while result is not taken the input register still accepts one more
//   request, then sensor.ready drops until the result is taken.
`default_nettype none

module hall_commutator_rev_counter import hcrc_pkg::*; (
	input  wire                         clk,
	input  wire                         arst_n,
	hcrc_in_if.sink                     sensor,
	hcrc_out_if.source                  result,
	input  wire                         wr_en,
	input  wire [REG_INDEX_WIDTH-1:0]   wr_index,
	input  wire [CFG_WIDTH-1:0]         wr_data
);

	logic [2:0]             rotor_origin_q;
	logic [2:0]             lead_steps_q;
	logic [15:0]            rev_limit_q;
	logic                   limit_enable_q;
	logic [1:0]             start_mode_q;

	logic                   valid_s1;
	hcrc_in_t               item_s1;
	logic                   out_valid_q;
	logic                   advance;

	logic [2:0]             last_hall_q, last_hall_nxt;
	logic [5:0]             gate_q, gate_nxt;
	logic [7:0]             duty_q, duty_nxt;
	logic [1:0]             mode_q, mode_nxt;
	logic [COUNT_WIDTH-1:0] rev_cnt_q, rev_cnt_nxt;
	logic [TIMER_WIDTH-1:0] tick_q, tick_nxt;
	logic [TIMER_WIDTH-1:0] period_q, period_nxt;

	function automatic logic [5:0] commutate(input logic [2:0] h, input logic [2:0] org,
			input logic [2:0] lead);
		logic [2:0]        st;
		logic signed [4:0] drv;
		logic [3:0]        idx;
		st  = ROTOR_DECODE[h];
		drv = $signed({2'b00, st}) - $signed({2'b00, org}) + $signed({{2{lead[2]}}, lead})
			+ 5'sd6;
		idx = drv[3:0];
		if (idx >= 4'd12) begin
			idx = idx - 4'd12;
		end else if (idx >= 4'd6) begin
			idx = idx - 4'd6;
		end
		if (st == ROTOR_INVALID || drv < 0) begin
			commutate = 6'h00;
		end else begin
			commutate = GATE_TABLE[idx[2:0]];
		end
	endfunction

	function automatic logic [OUT_WIDTH-1:0] sat_out(input logic [31:0] v);
		sat_out = (v > 32'hFFFF) ? {OUT_WIDTH{1'b1}} : v[OUT_WIDTH-1:0];
	endfunction

	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign sensor.ready = !valid_s1 || advance;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotor_origin_q <= 3'd0;
			lead_steps_q   <= LEAD_RESET;
			rev_limit_q    <= 16'd0;
			limit_enable_q <= 1'b0;
			start_mode_q   <= MODE_FULL;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ROTOR_ORIGIN: rotor_origin_q <= wr_data[2:0];
				REG_LEAD_STEPS:   lead_steps_q   <= wr_data[2:0];
				REG_REV_LIMIT:    rev_limit_q    <= wr_data[15:0];
				REG_LIMIT_ENABLE: limit_enable_q <= wr_data[0];
				REG_START_MODE:   start_mode_q   <= wr_data[1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sensor.ready) begin
			valid_s1 <= sensor.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sensor.ready && sensor.valid) begin
			item_s1 <= sensor.payload;
		end
	end

	always_comb begin
		last_hall_nxt = last_hall_q;
		gate_nxt      = gate_q;
		duty_nxt      = duty_q;
		mode_nxt      = mode_q;
		rev_cnt_nxt   = rev_cnt_q;
		tick_nxt      = tick_q;
		period_nxt    = period_q;
		if (item_s1.cmd == CMD_RESTART) begin
			rev_cnt_nxt   = '0;
			tick_nxt      = '0;
			period_nxt    = '0;
			duty_nxt      = DUTY_FULL;
			mode_nxt      = (start_mode_q == MODE_UNUSED) ? MODE_FULL : start_mode_q;
			last_hall_nxt = item_s1.hall;
			gate_nxt      = commutate(item_s1.hall, rotor_origin_q, lead_steps_q);
		end else begin
			if (tick_q != {TIMER_WIDTH{1'b1}}) begin
				tick_nxt = tick_q + 1'b1;
			end
			if (item_s1.hall != last_hall_q) begin
				// rising edge of sensor one
				if (item_s1.hall[0] && !last_hall_q[0]) begin
					period_nxt = tick_nxt;
					tick_nxt   = '0;
					if (rev_cnt_q != {COUNT_WIDTH{1'b1}}) begin
						rev_cnt_nxt = rev_cnt_q + 1'b1;
					end
					if (mode_q == MODE_POSITION) begin
						duty_nxt = item_s1.position_duty;
					end else if (mode_q == MODE_SPEED) begin
						duty_nxt = item_s1.speed_duty;
						if (limit_enable_q && (32'(rev_cnt_nxt) > 32'(rev_limit_q))) begin
							mode_nxt = MODE_POSITION;
						end
					end
				end
				gate_nxt      = commutate(item_s1.hall, rotor_origin_q, lead_steps_q);
				last_hall_nxt = item_s1.hall;
			end
		end
	end

	// state registers double as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_hall_q <= 3'd0;
			gate_q      <= 6'h00;
			duty_q      <= DUTY_FULL;
			mode_q      <= MODE_FULL;
			rev_cnt_q   <= '0;
			tick_q      <= '0;
			period_q    <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				last_hall_q <= last_hall_nxt;
				gate_q      <= gate_nxt;
				duty_q      <= duty_nxt;
				mode_q      <= mode_nxt;
				rev_cnt_q   <= rev_cnt_nxt;
				tick_q      <= tick_nxt;
				period_q    <= period_nxt;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid              = out_valid_q;
	assign result.payload.low_gates  = {gate_q[4], gate_q[2], gate_q[0]};
	assign result.payload.high_gates = {gate_q[5], gate_q[3], gate_q[1]};
	assign result.payload.duty       = duty_q;
	assign result.payload.rev_count  = sat_out(32'(rev_cnt_q));
	assign result.payload.rev_period = sat_out(32'(period_q));
	assign result.payload.mode       = mode_q;

	a_no_shoot_through: assert property (@(posedge clk) disable iff (!arst_n)
		(result.payload.low_gates & result.payload.high_gates) == 3'b000)
		else $error("low and high switch on in the same phase");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.cmd == CMD_RESTART) |=> (rev_cnt_q == '0 && period_q == '0
		&& duty_q == DUTY_FULL))
		else $error("restart did not clear counters");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.cmd == CMD_TICK) |=> (rev_cnt_q >= $past(rev_cnt_q)))
		else $error("revolution count went down on a tick");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |=> ($stable(gate_q) && $stable(rev_cnt_q)))
		else $error("state changed while result stalled");

endmodule

`default_nettype wire
